// File: src/tmr_pkg.sv
// ----------------------------------------------------------------------------
// tmr_pkg
// Types, codes and per-clock update functions for the divider timer with
// delayed reload.
// ----------------------------------------------------------------------------
package tmr_pkg;

  localparam int DIV_W  = 16;
  localparam int BYTE_W = 8;
  localparam int TAC_W  = 3;
  localparam int CNT_W  = 3;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_SPEED = 2'd3;

  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_TIMA = 2'd1;
  localparam logic [1:0] REG_TMA  = 2'd2;
  localparam logic [1:0] REG_TAC  = 2'd3;

  localparam logic [BYTE_W-1:0] TAC_READ_FILL = 8'hF8;

  typedef struct packed {
    logic [DIV_W-1:0]  div;
    logic [BYTE_W-1:0] tima;
    logic [BYTE_W-1:0] tma;
    logic [TAC_W-1:0]  tac;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] pend;
    logic              dbl;
  } tmr_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              timer_irq;
    logic              apu_clock;
  } tmr_result_t;

  typedef struct packed {
    tmr_state_t st;
    logic       irq;
    logic       apu;
  } tmr_clk_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        reg_index;
    logic [BYTE_W-1:0] write_data;
    logic              speed_mode;
  } tmr_item_t;

  // selected timer signal, gated by the enable bit
  function automatic logic tsig(input logic [DIV_W-1:0] div, input logic [TAC_W-1:0] ctl);
    logic b;
    unique case (ctl[1:0])
      2'd0:    b = div[9];
      2'd1:    b = div[3];
      2'd2:    b = div[5];
      default: b = div[7];
    endcase
    return ctl[2] & b;
  endfunction

  // sequencer signal
  function automatic logic asig(input logic [DIV_W-1:0] div, input logic dbl);
    return dbl ? div[5] : div[4];
  endfunction

  function automatic tmr_state_t bump(input tmr_state_t s, input logic [CNT_W-1:0] dly);
    tmr_state_t r;
    r = s;
    if (s.tima != 8'hFF) begin
      r.tima = s.tima + 8'd1;
    end else begin
      r.tima = '0;
      r.cnt  = dly;
      r.pend = s.tma;
    end
    return r;
  endfunction

  function automatic tmr_clk_t one_clock(input tmr_state_t s, input logic [CNT_W-1:0] dly);
    tmr_clk_t         r;
    logic             landed;
    logic [DIV_W-1:0] nd;
    r      = '0;
    r.st   = s;
    landed = 1'b0;
    nd     = s.div + 16'd1;
    if (s.cnt != '0) begin
      r.st.cnt = s.cnt - 3'd1;
      if (r.st.cnt == '0) begin
        r.st.tima = s.pend;
        r.irq     = 1'b1;
        landed    = 1'b1;
      end
    end
    if (!landed && tsig(s.div, s.tac) && !tsig(nd, s.tac)) begin
      r.st = bump(r.st, dly);
    end
    if (asig(s.div, s.dbl) && !asig(nd, s.dbl)) begin
      r.apu = 1'b1;
    end
    r.st.div = nd;
    return r;
  endfunction

endpackage

// File: src/divider_timer_with_delayed_reload_core.sv
// ----------------------------------------------------------------------------
// divider_timer_with_delayed_reload_core
// DIV/TIMA/TMA/TAC timer with delayed TIMA reload, stream in and out.
// ----------------------------------------------------------------------------
// channel | dir | fields (lsb first)
// in_     | in  | opcode[1:0] reg_index[3:2] write_data[11:4] speed_mode[12]
// out_    | out | read_data[7:0] timer_irq[8] apu_clock[9]
//
// one item per clock sustained while out_tready is high; each item passes
// the input register, then the state update and result register
// the timer state update is a single combinational pass per item
// synchronous active-low reset clears all timer state to zero
// a stalled output holds its result; the input register then fills and
// in_tready drops
// ----------------------------------------------------------------------------
module divider_timer_with_delayed_reload_core
  import tmr_pkg::*;
#(
  parameter int RELOAD_WAIT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // opcode, reg_index, write_data, speed_mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data, timer_irq, apu_clock
);

  logic        in_v_r;
  tmr_item_t   item_r;
  logic        out_v_r;
  tmr_result_t res_r;
  tmr_result_t res;
  logic        proc;
  logic        in_fire;

  assign proc      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (proc) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.opcode     <= in_tdata[1:0];
      item_r.reg_index  <= in_tdata[3:2];
      item_r.write_data <= in_tdata[11:4];
      item_r.speed_mode <= in_tdata[12];
    end
    if (proc) begin
      res_r <= res;
    end
  end

  tmr_engine #(
    .DLY(CNT_W'(RELOAD_WAIT))
  ) u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (proc),
    .item (item_r),
    .res  (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, res_r.apu_clock, res_r.timer_irq, res_r.read_data};

`ifndef SYNTHESIS
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r)
    else $error("input register empty while not ready");

  a_proc_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_tvalid)
    else $error("processed item did not reach output");

  a_read_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item_r.opcode != OP_READ |=> out_tdata[7:0] == 8'd0)
    else $error("read data on non-read item");

  a_irq_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item_r.opcode != OP_TICK |=> !out_tdata[8])
    else $error("timer irq on non-tick item");
`endif

endmodule

// File: src/tmr_engine.sv
// ----------------------------------------------------------------------------
// tmr_engine
// Timer state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module tmr_engine
  import tmr_pkg::*;
#(
  parameter logic [CNT_W-1:0] DLY = 3'd4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  tmr_item_t   item,
  output tmr_result_t res
);

  tmr_state_t st_r;
  tmr_state_t st_nxt;
  tmr_clk_t   c1;
  tmr_clk_t   c2;
  logic [TAC_W-1:0] nv;

  always_comb begin
    st_nxt = st_r;
    res    = '0;
    c1     = one_clock(st_r, DLY);
    c2     = one_clock(c1.st, DLY);
    nv     = item.write_data[TAC_W-1:0];
    if (fire) begin
      unique case (item.opcode)
        OP_TICK: begin
          if (st_r.dbl) begin
            st_nxt        = c2.st;
            res.timer_irq = c1.irq | c2.irq;
            res.apu_clock = c1.apu | c2.apu;
          end else begin
            st_nxt        = c1.st;
            res.timer_irq = c1.irq;
            res.apu_clock = c1.apu;
          end
        end
        OP_READ: begin
          unique case (item.reg_index)
            REG_DIV:  res.read_data = st_r.div[DIV_W-1 -: BYTE_W];
            REG_TIMA: res.read_data = st_r.tima;
            REG_TMA:  res.read_data = st_r.tma;
            default:  res.read_data = TAC_READ_FILL | {5'd0, st_r.tac};
          endcase
        end
        OP_WRITE: begin
          unique case (item.reg_index)
            REG_DIV: begin
              if (tsig(st_r.div, st_r.tac) && !tsig('0, st_r.tac)) begin
                st_nxt = bump(st_r, DLY);
              end
              res.apu_clock = asig(st_r.div, st_r.dbl) && !asig('0, st_r.dbl);
              st_nxt.div = '0;
            end
            REG_TIMA: begin
              st_nxt.tima = item.write_data;
              st_nxt.cnt  = '0;
              st_nxt.pend = st_r.tma;
            end
            REG_TMA: begin
              st_nxt.tma = item.write_data;
            end
            default: begin
              if (tsig(st_r.div, st_r.tac) && !tsig(st_r.div, nv)) begin
                st_nxt = bump(st_r, DLY);
              end
              st_nxt.tac = nv;
            end
          endcase
        end
        default: begin
          if (item.speed_mode != st_r.dbl) begin
            res.apu_clock = asig(st_r.div, st_r.dbl) && !asig(st_r.div, item.speed_mode);
            st_nxt.dbl    = item.speed_mode;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule
